>>> design/cbto_pkg.sv
package cbto_pkg;

   // Fixed sizes
   localparam int MAX_WIDTH     = 320;
   localparam int CAPTION_CHARS = 16;
   localparam int BAR_COUNT     = 8;

   localparam int XW          = 9;
   localparam int YW          = 10;
   localparam int COLOUR_W    = 16;
   localparam int CMP_W       = 11;
   localparam int SCALE_W     = 4;
   localparam int RGB_W       = 24;
   localparam int CHARS_W     = 64;
   localparam int CSR_DATA_W  = 64;
   localparam int CSR_ADDR_W  = 6;
   localparam int BAR_IDX_W   = $clog2(BAR_COUNT);
   localparam int BAR_PROD_W  = XW + $clog2(BAR_COUNT);
   localparam int CHAR_IDX_W  = $clog2(CAPTION_CHARS + 1);
   localparam int CHAR_SEL_W  = (CAPTION_CHARS > 1) ? $clog2(CAPTION_CHARS) : 1;
   localparam int CELL_W      = 7;
   localparam int GLYPH_W     = 6;
   localparam int FONT_COLS   = 5;
   localparam int FONT_ROWS   = 7;
   localparam int CELL_COLS   = 6;

   // Register reset values
   localparam logic [XW-1:0]      RST_FRAME_WIDTH   = 9'd320;
   localparam logic [YW-1:0]      RST_FRAME_HEIGHT  = 10'd240;
   localparam logic [XW-1:0]      RST_CAPTION_X     = 9'd10;
   localparam logic [YW-1:0]      RST_CAPTION_Y     = 10'd140;
   localparam logic [SCALE_W-1:0] RST_CAPTION_SCALE = 4'd4;
   localparam logic [RGB_W-1:0]   RST_CAPTION_RGB   = 24'hFFB000;

   // Font range after case folding
   localparam logic [7:0] FONT_FIRST  = 8'h20;
   localparam logic [7:0] FONT_LAST   = 8'h5F;
   localparam logic [7:0] LOWER_FIRST = 8'h61;
   localparam logic [7:0] LOWER_LAST  = 8'h7A;
   localparam logic [7:0] CASE_OFFSET = 8'h20;
   localparam logic [7:0] CHAR_QMARK  = 8'h3F;

   typedef enum logic [2:0] {
      REG_FRAME_WIDTH   = 3'd0,
      REG_FRAME_HEIGHT  = 3'd1,
      REG_CAPTION_X     = 3'd2,
      REG_CAPTION_Y     = 3'd3,
      REG_CAPTION_SCALE = 3'd4,
      REG_CAPTION_RGB   = 3'd5,
      REG_CHARS_FIRST   = 3'd6,
      REG_CHARS_SECOND  = 3'd7
   } reg_index_type;

   typedef struct packed {
      logic [XW-1:0]      frame_width;
      logic [YW-1:0]      frame_height;
      logic [XW-1:0]      caption_x;
      logic [YW-1:0]      caption_y;
      logic [SCALE_W-1:0] caption_scale;
      logic [RGB_W-1:0]   caption_rgb;
      logic [CHARS_W-1:0] chars_first;
      logic [CHARS_W-1:0] chars_second;
   } cfg_type;

   // Load enables, one per pipeline stage
   typedef struct packed {
      logic s1;
      logic s2;
      logic s3;
      logic s4;
   } stage_en_type;

   // Position of a pixel relative to the caption grid
   typedef struct packed {
      logic                  win;
      logic [XW-1:0]         dx;
      logic [2:0]            gy;
      logic [CHAR_IDX_W-1:0] char_idx;
      logic [BAR_IDX_W-1:0]  bar;
      logic                  top;
   } loc_type;

   // Glyph columns, leftmost column in the top byte; bit g is glyph row g
   localparam logic [39:0] FONT_ROM [64] = '{
      40'h0000000000, 40'h00005f0000, 40'h0007000700, 40'h147f147f14,
      40'h242a7f2a12, 40'h2313086462, 40'h3649552250, 40'h0005030000,
      40'h001c224100, 40'h0041221c00, 40'h14083e0814, 40'h08083e0808,
      40'h0050300000, 40'h0808080808, 40'h0060600000, 40'h2010080402,
      40'h3e5149453e, 40'h00427f4000, 40'h4261514946, 40'h2141454b31,
      40'h1814127f10, 40'h2745454539, 40'h3c4a494930, 40'h0171090503,
      40'h3649494936, 40'h064949291e, 40'h0036360000, 40'h0056360000,
      40'h0814224100, 40'h1414141414, 40'h0041221408, 40'h0201510906,
      40'h324979413e, 40'h7e1111117e, 40'h7f49494936, 40'h3e41414122,
      40'h7f4141221c, 40'h7f49494941, 40'h7f09090901, 40'h3e4149497a,
      40'h7f0808087f, 40'h00417f4100, 40'h2040413f01, 40'h7f08142241,
      40'h7f40404040, 40'h7f020c027f, 40'h7f0408107f, 40'h3e4141413e,
      40'h7f09090906, 40'h3e4151215e, 40'h7f09192946, 40'h4649494931,
      40'h01017f0101, 40'h3f4040403f, 40'h1f2040201f, 40'h7f2018207f,
      40'h6314081463, 40'h0304780403, 40'h6151494543, 40'h007f414100,
      40'h0204081020, 40'h0041417f00, 40'h0402010204, 40'h4040404040
   };

   localparam logic [RGB_W-1:0] BAR_RGB [8] = '{
      24'hFFFFFF, 24'hFFFF00, 24'h00FFFF, 24'h00FF00,
      24'hFF00FF, 24'hFF0000, 24'h0000FF, 24'h000000
   };

   function automatic logic [7:0] font_column(input logic [GLYPH_W-1:0] glyph,
                                               input logic [2:0] col);
      logic [39:0] cols;
      logic [7:0]  result;
      cols = FONT_ROM[glyph];
      unique case (col)
         3'd0:    result = cols[39:32];
         3'd1:    result = cols[31:24];
         3'd2:    result = cols[23:16];
         3'd3:    result = cols[15:8];
         3'd4:    result = cols[7:0];
         default: result = 8'h00;
      endcase
      return result;
   endfunction

   // RGB888 to byte-swapped RGB565
   function automatic logic [COLOUR_W-1:0] to_panel565(input logic [RGB_W-1:0] rgb);
      logic [COLOUR_W-1:0] v;
      v = {rgb[23:19], rgb[15:10], rgb[7:3]};
      return {v[7:0], v[15:8]};
   endfunction

   function automatic logic [GLYPH_W-1:0] glyph_of(input logic [7:0] c);
      logic [7:0] f;
      f = c;
      if (f >= LOWER_FIRST && f <= LOWER_LAST) begin
         f = f - CASE_OFFSET;
      end
      if (f < FONT_FIRST || f > FONT_LAST) begin
         f = CHAR_QMARK;
      end
      f = f - FONT_FIRST;
      return f[GLYPH_W-1:0];
   endfunction

endpackage

>>> design/cbto_csr.sv
module cbto_csr (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_psel,
   input  logic                           csr_penable,
   input  logic                           csr_pwrite,
   input  logic [cbto_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [cbto_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [cbto_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                           csr_pready,
   output cbto_pkg::cfg_type              cfg
);
   import cbto_pkg::*;

   cfg_type       cfg_ff;
   cfg_type       cfg_in;
   reg_index_type index;
   logic          wr_en;

   assign index      = reg_index_type'(csr_paddr[CSR_ADDR_W-1:3]);
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;
   assign cfg        = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (index)
            REG_FRAME_WIDTH:   cfg_in.frame_width   = csr_pwdata[XW-1:0];
            REG_FRAME_HEIGHT:  cfg_in.frame_height  = csr_pwdata[YW-1:0];
            REG_CAPTION_X:     cfg_in.caption_x     = csr_pwdata[XW-1:0];
            REG_CAPTION_Y:     cfg_in.caption_y     = csr_pwdata[YW-1:0];
            REG_CAPTION_SCALE: cfg_in.caption_scale = csr_pwdata[SCALE_W-1:0];
            REG_CAPTION_RGB:   cfg_in.caption_rgb   = csr_pwdata[RGB_W-1:0];
            REG_CHARS_FIRST:   cfg_in.chars_first   = csr_pwdata;
            REG_CHARS_SECOND:  cfg_in.chars_second  = csr_pwdata;
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      unique case (index)
         REG_FRAME_WIDTH:   csr_prdata = CSR_DATA_W'(cfg_ff.frame_width);
         REG_FRAME_HEIGHT:  csr_prdata = CSR_DATA_W'(cfg_ff.frame_height);
         REG_CAPTION_X:     csr_prdata = CSR_DATA_W'(cfg_ff.caption_x);
         REG_CAPTION_Y:     csr_prdata = CSR_DATA_W'(cfg_ff.caption_y);
         REG_CAPTION_SCALE: csr_prdata = CSR_DATA_W'(cfg_ff.caption_scale);
         REG_CAPTION_RGB:   csr_prdata = CSR_DATA_W'(cfg_ff.caption_rgb);
         REG_CHARS_FIRST:   csr_prdata = cfg_ff.chars_first;
         REG_CHARS_SECOND:  csr_prdata = cfg_ff.chars_second;
         default:           csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.frame_width   <= RST_FRAME_WIDTH;
         cfg_ff.frame_height  <= RST_FRAME_HEIGHT;
         cfg_ff.caption_x     <= RST_CAPTION_X;
         cfg_ff.caption_y     <= RST_CAPTION_Y;
         cfg_ff.caption_scale <= RST_CAPTION_SCALE;
         cfg_ff.caption_rgb   <= RST_CAPTION_RGB;
         cfg_ff.chars_first   <= '0;
         cfg_ff.chars_second  <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

>>> design/cbto_locate.sv
module cbto_locate (
   input  logic                       clock,
   input  cbto_pkg::cfg_type          cfg,
   input  cbto_pkg::stage_en_type     en,
   input  logic [cbto_pkg::XW-1:0]    pixel_x,
   input  logic [cbto_pkg::YW-1:0]    pixel_y,
   output cbto_pkg::loc_type          loc
);
   import cbto_pkg::*;

   // stage 1: caption window, offsets, bar index
   logic                 win_s1_ff, win_s1_in;
   logic [XW-1:0]        dx_s1_ff, dx_s1_in;
   logic [YW-1:0]        dy_s1_ff, dy_s1_in;
   logic [BAR_IDX_W-1:0] bar_s1_ff, bar_s1_in;
   logic                 top_s1_ff, top_s1_in;

   logic [BAR_PROD_W-1:0] x_prod;
   logic [CMP_W-1:0]      y_end;

   // stage 2: glyph row and character slot
   loc_type loc_ff, loc_in;

   logic [CELL_W-1:0] pitch;

   always_comb begin
      // bar = floor(x*N/w), found as the largest k with x*N >= k*w
      x_prod    = BAR_PROD_W'(pixel_x) * BAR_PROD_W'(BAR_COUNT);
      bar_s1_in = '0;
      for (int k = 1; k < BAR_COUNT; k++) begin
         if (x_prod >= BAR_PROD_W'(k) * BAR_PROD_W'(cfg.frame_width)) begin
            bar_s1_in = BAR_IDX_W'(k);
         end
      end
      top_s1_in = pixel_y < {1'b0, cfg.frame_height[YW-1:1]};

      y_end = CMP_W'(cfg.caption_y) + CMP_W'(cfg.caption_scale) * CMP_W'(FONT_ROWS);
      win_s1_in = (cfg.caption_scale != '0)
               && (pixel_x < cfg.frame_width)
               && (CMP_W'(pixel_x) < CMP_W'(MAX_WIDTH))
               && (pixel_y >= cfg.caption_y)
               && (CMP_W'(pixel_y) < y_end)
               && (pixel_x >= cfg.caption_x);
      dx_s1_in = pixel_x - cfg.caption_x;
      dy_s1_in = pixel_y - cfg.caption_y;
   end

   always_ff @(posedge clock) begin
      if (en.s1) begin
         win_s1_ff <= win_s1_in;
         dx_s1_ff  <= dx_s1_in;
         dy_s1_ff  <= dy_s1_in;
         bar_s1_ff <= bar_s1_in;
         top_s1_ff <= top_s1_in;
      end
   end

   always_comb begin
      pitch = CELL_W'(cfg.caption_scale) * CELL_W'(CELL_COLS);
      loc_in.win = win_s1_ff;
      loc_in.dx  = dx_s1_ff;
      loc_in.bar = bar_s1_ff;
      loc_in.top = top_s1_ff;
      loc_in.gy  = '0;
      for (int k = 1; k < FONT_ROWS; k++) begin
         if (dy_s1_ff >= YW'(k) * YW'(cfg.caption_scale)) begin
            loc_in.gy = 3'(k);
         end
      end
      loc_in.char_idx = '0;
      for (int k = 1; k <= CAPTION_CHARS; k++) begin
         if (CMP_W'(dx_s1_ff) >= CMP_W'(k) * CMP_W'(pitch)) begin
            loc_in.char_idx = CHAR_IDX_W'(k);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en.s2) begin
         loc_ff <= loc_in;
      end
   end

   assign loc = loc_ff;

endmodule

>>> design/cbto_render.sv
module cbto_render (
   input  logic                           clock,
   input  cbto_pkg::cfg_type              cfg,
   input  cbto_pkg::stage_en_type         en,
   input  cbto_pkg::loc_type              loc,
   output logic [cbto_pkg::COLOUR_W-1:0]  pixel_colour
);
   import cbto_pkg::*;

   // stage 3: font column, glyph code
   logic                 hit_s3_ff, hit_s3_in;
   logic [GLYPH_W-1:0]   glyph_s3_ff, glyph_s3_in;
   logic [2:0]           col_s3_ff, col_s3_in;
   logic [2:0]           gy_s3_ff;
   logic [BAR_IDX_W-1:0] bar_s3_ff;
   logic                 top_s3_ff;

   logic [COLOUR_W-1:0]  colour_ff, colour_in;

   logic [CELL_W-1:0]             pitch;
   logic [CMP_W-1:0]              slot_start;
   logic [XW-1:0]                 rem;
   logic [8*CAPTION_CHARS-1:0]    chars;
   logic [CAPTION_CHARS-1:0]      live;
   logic                          run;
   logic [CHAR_SEL_W-1:0]         sel;
   logic                          slot_ok;
   logic [7:0]                    char_code;
   logic [7:0]                    column;
   logic                          dot;

   always_comb begin
      pitch      = CELL_W'(cfg.caption_scale) * CELL_W'(CELL_COLS);
      slot_start = CMP_W'(loc.char_idx) * CMP_W'(pitch);
      rem        = XW'(CMP_W'(loc.dx) - slot_start);
      col_s3_in  = '0;
      for (int k = 1; k <= FONT_COLS; k++) begin
         if (rem >= XW'(k) * XW'(cfg.caption_scale)) begin
            col_s3_in = 3'(k);
         end
      end

      // slot i is drawn only if bytes 0..i are all nonzero
      chars = (8*CAPTION_CHARS)'({cfg.chars_second, cfg.chars_first});
      run   = 1'b1;
      for (int k = 0; k < CAPTION_CHARS; k++) begin
         run     = run && (chars[8*k +: 8] != 8'h00);
         live[k] = run;
      end
      sel       = CHAR_SEL_W'(loc.char_idx);
      slot_ok   = (CMP_W'(loc.char_idx) < CMP_W'(CAPTION_CHARS)) && live[sel];
      char_code = chars[8*sel +: 8];

      glyph_s3_in = glyph_of(char_code);
      hit_s3_in   = loc.win && slot_ok && (col_s3_in < 3'(FONT_COLS));
   end

   always_ff @(posedge clock) begin
      if (en.s3) begin
         hit_s3_ff   <= hit_s3_in;
         glyph_s3_ff <= glyph_s3_in;
         col_s3_ff   <= col_s3_in;
         gy_s3_ff    <= loc.gy;
         bar_s3_ff   <= loc.bar;
         top_s3_ff   <= loc.top;
      end
   end

   always_comb begin
      column = font_column(glyph_s3_ff, col_s3_ff);
      dot    = hit_s3_ff && column[gy_s3_ff];
      if (dot) begin
         colour_in = to_panel565(cfg.caption_rgb);
      end else if (top_s3_ff) begin
         colour_in = to_panel565(BAR_RGB[3'(bar_s3_ff)]);
      end else begin
         colour_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (en.s4) begin
         colour_ff <= colour_in;
      end
   end

   assign pixel_colour = colour_ff;

endmodule

>>> design/color_bar_text_overlay_generator.sv
// Color-bar test pattern with a configurable 5x7 caption.
//
// Input channel (req_*): one pixel coordinate per beat, pixel_x and pixel_y.
// Result channel (rsp_*): one byte-swapped RGB565 color per input beat, in
// order. Both channels accept a beat when valid is high and stall is low.
// Configuration goes through the APB-style csr_* port, 64-bit registers at
// byte address 8*index; registers should be written only while no pixel is
// in flight.
//
// An accepted input beat passes four register stages on its way to rsp_*
// (window and bar index, glyph row and character slot, font column, output
// color). Throughput is one pixel per clock while rsp_stall stays low.
//
// Reset clears all stage valid bits and loads the default register values.
// When the receiver stalls, the output beat holds and the stages behind it
// fill up; req_stall rises once the pipeline is full, and nothing is dropped
// or repeated.
module color_bar_text_overlay_generator (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [cbto_pkg::XW-1:0]         req_pixel_x,
   input  logic [cbto_pkg::YW-1:0]         req_pixel_y,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [cbto_pkg::COLOUR_W-1:0]   rsp_pixel_colour,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [cbto_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [cbto_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [cbto_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                            csr_pready
);
   import cbto_pkg::*;

   cfg_type      cfg;
   stage_en_type en;
   loc_type      loc;

   logic v1_ff, v1_in;
   logic v2_ff, v2_in;
   logic v3_ff, v3_in;
   logic v4_ff, v4_in;

   // a stage loads when it is empty or its contents move on
   always_comb begin
      en.s4 = !v4_ff || !rsp_stall;
      en.s3 = !v3_ff || en.s4;
      en.s2 = !v2_ff || en.s3;
      en.s1 = !v1_ff || en.s2;

      v1_in = en.s1 ? req_valid : v1_ff;
      v2_in = en.s2 ? v1_ff     : v2_ff;
      v3_in = en.s3 ? v2_ff     : v3_ff;
      v4_in = en.s4 ? v3_ff     : v4_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
         v3_ff <= v3_in;
         v4_ff <= v4_in;
      end
   end

   assign req_stall = !en.s1;
   assign rsp_valid = v4_ff;

   cbto_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   cbto_locate u_locate (
      .clock   (clock),
      .cfg     (cfg),
      .en      (en),
      .pixel_x (req_pixel_x),
      .pixel_y (req_pixel_y),
      .loc     (loc)
   );

   cbto_render u_render (
      .clock        (clock),
      .cfg          (cfg),
      .en           (en),
      .loc          (loc),
      .pixel_colour (rsp_pixel_colour)
   );

endmodule
